>>> hw/rtl/i2crs_pkg.sv
// Shared types and constants for the I2C register read sequencer.
package i2crs_pkg;

   // Operation codes of an input transaction.
   localparam logic [1:0] OP_BEGIN = 2'd0;
   localparam logic [1:0] OP_EVENT = 2'd1;
   localparam logic [1:0] OP_TICK  = 2'd2;

   // Bus command codes of a result transaction.
   localparam logic [2:0] CMD_NONE  = 3'd0;
   localparam logic [2:0] CMD_START = 3'd1;
   localparam logic [2:0] CMD_TX    = 3'd2;
   localparam logic [2:0] CMD_RXACK = 3'd3;
   localparam logic [2:0] CMD_RXNAK = 3'd4;
   localparam logic [2:0] CMD_STOP  = 3'd5;

   // Bus status codes, compared after masking the low three bits.
   localparam logic [7:0] ST_START   = 8'h08;
   localparam logic [7:0] ST_RSTART  = 8'h10;
   localparam logic [7:0] ST_MT_SLA  = 8'h18;
   localparam logic [7:0] ST_MT_DATA = 8'h28;
   localparam logic [7:0] ST_MR_SLA  = 8'h40;
   localparam logic [7:0] ST_MR_ACK  = 8'h50;
   localparam logic [7:0] ST_MR_NACK = 8'h58;
   localparam logic [7:0] ST_MASK    = 8'hF8;

   // Configuration register indexes.
   localparam logic [1:0] CSR_SLAVE_ADDRESS  = 2'd0;
   localparam logic [1:0] CSR_START_REGISTER = 2'd1;
   localparam logic [1:0] CSR_READ_LENGTH    = 2'd2;
   localparam logic [1:0] CSR_WAIT_LIMIT     = 2'd3;

   localparam int unsigned CSR_DATA_W = 16;

   // Configuration reset values.
   localparam logic [6:0]  RST_SLAVE_ADDRESS  = 7'd18;
   localparam logic [7:0]  RST_START_REGISTER = 8'd0;
   localparam logic [7:0]  RST_READ_LENGTH    = 8'd4;
   localparam logic [15:0] RST_WAIT_LIMIT     = 16'hFFFF;

   typedef enum logic [2:0] {
      PH_IDLE   = 3'd0,
      PH_START1 = 3'd1,
      PH_SLAW   = 3'd2,
      PH_REGW   = 3'd3,
      PH_START2 = 3'd4,
      PH_SLAR   = 3'd5,
      PH_READ   = 3'd6
   } phase_type;

   typedef struct packed {
      logic [6:0]  slave_address;
      logic [7:0]  start_register;
      logic [7:0]  read_length;
      logic [15:0] wait_limit;
   } cfg_type;

   typedef struct packed {
      logic [1:0] operation;
      logic [7:0] bus_status;
      logic [7:0] bus_data;
   } req_type;

   typedef struct packed {
      logic [2:0] bus_command;
      logic [7:0] tx_byte;
      logic       rx_valid;
      logic [7:0] rx_byte;
      logic [7:0] rx_index;
      logic       done_res;
      logic       success;
   } rsp_type;

endpackage

>>> hw/rtl/i2crs_csr.sv
// Configuration registers of the I2C register read sequencer.
module i2crs_csr (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              csr_we,
   input  logic [1:0]                        csr_index,
   input  logic [i2crs_pkg::CSR_DATA_W-1:0]  csr_wdata,
   output i2crs_pkg::cfg_type                cfg
);

   i2crs_pkg::cfg_type cfg_ff;
   i2crs_pkg::cfg_type cfg_in;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_we) begin
         case (csr_index)
            i2crs_pkg::CSR_SLAVE_ADDRESS:  cfg_in.slave_address  = csr_wdata[6:0];
            i2crs_pkg::CSR_START_REGISTER: cfg_in.start_register = csr_wdata[7:0];
            i2crs_pkg::CSR_READ_LENGTH:    cfg_in.read_length    = csr_wdata[7:0];
            i2crs_pkg::CSR_WAIT_LIMIT:     cfg_in.wait_limit     = csr_wdata[15:0];
            default:                       cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.slave_address  <= i2crs_pkg::RST_SLAVE_ADDRESS;
         cfg_ff.start_register <= i2crs_pkg::RST_START_REGISTER;
         cfg_ff.read_length    <= i2crs_pkg::RST_READ_LENGTH;
         cfg_ff.wait_limit     <= i2crs_pkg::RST_WAIT_LIMIT;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

>>> hw/rtl/i2crs_seq.sv
// Phase sequencer: bus state, byte counter, wait timer and result decode.
module i2crs_seq (
   input  logic               clock,
   input  logic               reset,
   input  logic               step_en,
   input  i2crs_pkg::req_type req,
   input  i2crs_pkg::cfg_type cfg,
   output i2crs_pkg::rsp_type rsp
);

   i2crs_pkg::phase_type phase_ff, phase_in;
   logic [7:0]  bytes_read_ff, bytes_read_in;
   logic [15:0] wait_left_ff, wait_left_in;

   logic [7:0] st;
   logic       is_begin, is_event, is_tick, busy;
   logic       is_start_code, ev_ok, ack_cur, ack_after, read_end;
   logic       abort, complete, early;
   logic [7:0] bytes_inc;
   logic [7:0] read_code;

   assign st        = req.bus_status & i2crs_pkg::ST_MASK;
   assign is_begin  = (req.operation == i2crs_pkg::OP_BEGIN);
   assign is_event  = (req.operation == i2crs_pkg::OP_EVENT);
   assign is_tick   = (req.operation == i2crs_pkg::OP_TICK);
   assign busy      = (phase_ff != i2crs_pkg::PH_IDLE);
   assign bytes_inc = bytes_read_ff + 8'd1;

   // A read is acknowledged while at least one more byte follows it.
   assign ack_cur   = ({1'b0, bytes_read_ff} + 9'd1) < {1'b0, cfg.read_length};
   assign ack_after = ({1'b0, bytes_inc} + 9'd1) < {1'b0, cfg.read_length};
   assign read_end  = (bytes_inc >= cfg.read_length) || (bytes_inc == 8'd0);
   assign read_code = ack_cur ? i2crs_pkg::ST_MR_ACK : i2crs_pkg::ST_MR_NACK;

   assign is_start_code = (st == i2crs_pkg::ST_START) || (st == i2crs_pkg::ST_RSTART);

   always_comb begin
      case (phase_ff)
         i2crs_pkg::PH_START1: ev_ok = is_start_code;
         i2crs_pkg::PH_SLAW:   ev_ok = (st == i2crs_pkg::ST_MT_SLA);
         i2crs_pkg::PH_REGW:   ev_ok = (st == i2crs_pkg::ST_MT_DATA);
         i2crs_pkg::PH_START2: ev_ok = is_start_code;
         i2crs_pkg::PH_SLAR:   ev_ok = (st == i2crs_pkg::ST_MR_SLA);
         i2crs_pkg::PH_READ:   ev_ok = (st == read_code);
         default:              ev_ok = 1'b0;
      endcase
   end

   assign abort = busy && ((is_event && !ev_ok)
                           || (is_tick && (wait_left_ff <= 16'd1)));
   assign complete = is_event && ev_ok
                     && (((phase_ff == i2crs_pkg::PH_SLAR)
                          && (bytes_read_ff >= cfg.read_length))
                         || ((phase_ff == i2crs_pkg::PH_READ) && read_end));
   // An abort before the address is acknowledged leaves the bus without a STOP.
   assign early = (phase_ff == i2crs_pkg::PH_START1) || (phase_ff == i2crs_pkg::PH_SLAW);

   // Next state.
   always_comb begin
      phase_in      = phase_ff;
      bytes_read_in = bytes_read_ff;
      wait_left_in  = wait_left_ff;
      if (step_en) begin
         if (is_begin && !busy) begin
            bytes_read_in = 8'd0;
            phase_in      = i2crs_pkg::PH_START1;
            wait_left_in  = cfg.wait_limit;
         end else if (abort || complete) begin
            phase_in     = i2crs_pkg::PH_IDLE;
            wait_left_in = 16'd0;
         end else if (is_tick && busy) begin
            wait_left_in = wait_left_ff - 16'd1;
         end else if (is_event && ev_ok) begin
            wait_left_in = cfg.wait_limit;
            case (phase_ff)
               i2crs_pkg::PH_START1: phase_in = i2crs_pkg::PH_SLAW;
               i2crs_pkg::PH_SLAW:   phase_in = i2crs_pkg::PH_REGW;
               i2crs_pkg::PH_REGW:   phase_in = i2crs_pkg::PH_START2;
               i2crs_pkg::PH_START2: phase_in = i2crs_pkg::PH_SLAR;
               i2crs_pkg::PH_SLAR:   phase_in = i2crs_pkg::PH_READ;
               i2crs_pkg::PH_READ:   phase_in = i2crs_pkg::PH_READ;
               default:              phase_in = phase_ff;
            endcase
         end
         if (is_event && ev_ok && (phase_ff == i2crs_pkg::PH_READ)) begin
            bytes_read_in = bytes_inc;
         end
      end
   end

   // Result decode.
   always_comb begin
      rsp = '0;
      if (is_begin && !busy) begin
         rsp.bus_command = i2crs_pkg::CMD_START;
      end else if (abort || complete) begin
         rsp.bus_command = early ? i2crs_pkg::CMD_NONE : i2crs_pkg::CMD_STOP;
         rsp.done_res    = 1'b1;
         rsp.success     = complete;
      end else if (is_event && ev_ok) begin
         case (phase_ff)
            i2crs_pkg::PH_START1: begin
               rsp.bus_command = i2crs_pkg::CMD_TX;
               rsp.tx_byte     = {cfg.slave_address, 1'b0};
            end
            i2crs_pkg::PH_SLAW: begin
               rsp.bus_command = i2crs_pkg::CMD_TX;
               rsp.tx_byte     = cfg.start_register;
            end
            i2crs_pkg::PH_REGW: begin
               rsp.bus_command = i2crs_pkg::CMD_START;
            end
            i2crs_pkg::PH_START2: begin
               rsp.bus_command = i2crs_pkg::CMD_TX;
               rsp.tx_byte     = {cfg.slave_address, 1'b1};
            end
            i2crs_pkg::PH_SLAR: begin
               rsp.bus_command = ack_cur ? i2crs_pkg::CMD_RXACK : i2crs_pkg::CMD_RXNAK;
            end
            i2crs_pkg::PH_READ: begin
               rsp.bus_command = ack_after ? i2crs_pkg::CMD_RXACK : i2crs_pkg::CMD_RXNAK;
            end
            default: begin
               rsp.bus_command = i2crs_pkg::CMD_NONE;
            end
         endcase
      end
      if (is_event && ev_ok && (phase_ff == i2crs_pkg::PH_READ)) begin
         rsp.rx_valid = 1'b1;
         rsp.rx_byte  = req.bus_data;
         rsp.rx_index = bytes_read_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff      <= i2crs_pkg::PH_IDLE;
         bytes_read_ff <= 8'd0;
         wait_left_ff  <= 16'd0;
      end else begin
         phase_ff      <= phase_in;
         bytes_read_ff <= bytes_read_in;
         wait_left_ff  <= wait_left_in;
      end
   end

endmodule

>>> hw/rtl/i2c_register_read_sequencer.sv
// I2C master register read sequencer: top level with input and result registers.
//
// Input channel (req_*): each transaction is a begin, a completed bus event with
// its status and data byte, or one wait tick. Result channel (rsp_*): exactly one
// transaction per input transaction, in order, carrying the bus command to issue,
// the byte to transmit, a received byte with its index, and the done and success
// flags. Configuration (csr_*) is written with csr_we, one register per cycle;
// the user must write only while idle; the block does not enforce this.
// The input register loads at the accepting edge; the result register loads
// from it when it is free or its result is being taken, and rsp_valid rises
// with it. Throughput is one transaction per cycle while the receiver does not
// stall; the phase state is updated in the same cycle that the result register
// loads.
// Reset clears the phase to idle, the counters to zero and the configuration
// registers to their defaults; both channels come up empty.
// When the receiver stalls, the result register holds, the input register takes
// one more transaction, and req_ready then falls until rsp_ready returns.
module i2c_register_read_sequencer (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [1:0]  req_operation,
   input  logic [7:0]  req_bus_status,
   input  logic [7:0]  req_bus_data,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [2:0]  rsp_bus_command,
   output logic [7:0]  rsp_tx_byte,
   output logic        rsp_rx_valid,
   output logic [7:0]  rsp_rx_byte,
   output logic [7:0]  rsp_rx_index,
   output logic        rsp_done_res,
   output logic        rsp_success,
   input  logic        csr_we,
   input  logic [1:0]  csr_index,
   input  logic [15:0] csr_wdata
);

   i2crs_pkg::cfg_type cfg;
   i2crs_pkg::req_type req_ff, req_in;
   i2crs_pkg::rsp_type rsp_ff, step_rsp;
   logic               in_valid_ff, in_valid_in;
   logic               out_valid_ff, out_valid_in;
   logic               advance;

   assign advance   = in_valid_ff && (!out_valid_ff || rsp_ready);
   assign req_ready = !in_valid_ff || advance;

   assign req_in.operation  = req_operation;
   assign req_in.bus_status = req_bus_status;
   assign req_in.bus_data   = req_bus_data;

   always_comb begin
      in_valid_in = req_ready ? req_valid : in_valid_ff;
      if (advance) begin
         out_valid_in = 1'b1;
      end else if (rsp_ready) begin
         out_valid_in = 1'b0;
      end else begin
         out_valid_in = out_valid_ff;
      end
   end

   i2crs_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .cfg       (cfg)
   );

   i2crs_seq u_seq (
      .clock   (clock),
      .reset   (reset),
      .step_en (advance),
      .req     (req_ff),
      .cfg     (cfg),
      .rsp     (step_rsp)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_ready) begin
         req_ff <= req_in;
      end
      if (advance) begin
         rsp_ff <= step_rsp;
      end
   end

   assign rsp_valid       = out_valid_ff;
   assign rsp_bus_command = rsp_ff.bus_command;
   assign rsp_tx_byte     = rsp_ff.tx_byte;
   assign rsp_rx_valid    = rsp_ff.rx_valid;
   assign rsp_rx_byte     = rsp_ff.rx_byte;
   assign rsp_rx_index    = rsp_ff.rx_index;
   assign rsp_done_res    = rsp_ff.done_res;
   assign rsp_success     = rsp_ff.success;

endmodule

>>> hw/rtl/i2crs_checker.sv
// Port-level assertions for the I2C register read sequencer, bound to the top level.
module i2crs_checker (
   input logic        clock,
   input logic        reset,
   input logic        rsp_valid,
   input logic        rsp_ready,
   input logic [2:0]  rsp_bus_command,
   input logic [7:0]  rsp_tx_byte,
   input logic        rsp_rx_valid,
   input logic [7:0]  rsp_rx_byte,
   input logic [7:0]  rsp_rx_index,
   input logic        rsp_done_res,
   input logic        rsp_success
);

   // Only a transmit command carries a byte to send.
   a_tx_only_on_transmit: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_bus_command != i2crs_pkg::CMD_TX) |-> (rsp_tx_byte == 8'd0))
      else $error("tx_byte set without a transmit command");

   // Received byte fields are zero unless a byte is delivered.
   a_rx_fields_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_rx_valid |-> (rsp_rx_byte == 8'd0) && (rsp_rx_index == 8'd0))
      else $error("rx fields set without a received byte");

   // A successful finish always releases the bus with a STOP.
   a_success_stops: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_done_res && rsp_success |-> (rsp_bus_command == i2crs_pkg::CMD_STOP))
      else $error("successful finish without STOP");

   // Success is only reported together with done.
   a_success_needs_done: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_done_res |-> !rsp_success)
      else $error("success without done");

   // A stalled result holds its command.
   a_stall_holds: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_bus_command))
      else $error("result changed while stalled");

endmodule

bind i2c_register_read_sequencer i2crs_checker u_i2crs_checker (
   .clock           (clock),
   .reset           (reset),
   .rsp_valid       (rsp_valid),
   .rsp_ready       (rsp_ready),
   .rsp_bus_command (rsp_bus_command),
   .rsp_tx_byte     (rsp_tx_byte),
   .rsp_rx_valid    (rsp_rx_valid),
   .rsp_rx_byte     (rsp_rx_byte),
   .rsp_rx_index    (rsp_rx_index),
   .rsp_done_res    (rsp_done_res),
   .rsp_success     (rsp_success)
);

>>> tb/i2crs_read_checker.sv
// Result checker for the I2C register read sequencer: predicts every result and compares.
module i2crs_read_checker (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   input  logic        req_ready,
   input  logic [1:0]  req_operation,
   input  logic [7:0]  req_bus_status,
   input  logic [7:0]  req_bus_data,
   input  logic        rsp_valid,
   input  logic        rsp_ready,
   input  logic [2:0]  rsp_bus_command,
   input  logic [7:0]  rsp_tx_byte,
   input  logic        rsp_rx_valid,
   input  logic [7:0]  rsp_rx_byte,
   input  logic [7:0]  rsp_rx_index,
   input  logic        rsp_done_res,
   input  logic        rsp_success,
   input  logic        csr_we,
   input  logic [1:0]  csr_index,
   input  logic [15:0] csr_wdata,
   output int          errors,
   output int          pending,
   output int          reads_ok,
   output int          reads_aborted,
   output int          bytes_delivered
);
   timeunit 1ns;
   timeprecision 1ps;

   i2crs_pkg::cfg_type   cfg;
   i2crs_pkg::phase_type seq_phase;
   logic [7:0]           byte_count;
   logic [15:0]          ticks_left;
   i2crs_pkg::rsp_type   predicted_rsp;
   i2crs_pkg::rsp_type   expected_responses[$];

   function automatic bit ack_wanted();
      return ({1'b0, byte_count} + 9'd1) < {1'b0, cfg.read_length};
   endfunction

   function automatic void issue_command(input logic [2:0] command, input logic [7:0] data);
      predicted_rsp.bus_command = command;
      predicted_rsp.tx_byte = (command == i2crs_pkg::CMD_TX) ? data : 8'd0;
      ticks_left = cfg.wait_limit;
   endfunction

   // A failure before the slave has acknowledged the write address leaves the bus
   // without a STOP; every later ending sends one.
   function automatic void end_read(input bit ok);
      bit early;
      early = (seq_phase == i2crs_pkg::PH_START1) || (seq_phase == i2crs_pkg::PH_SLAW);
      predicted_rsp.bus_command = (ok || !early) ? i2crs_pkg::CMD_STOP : i2crs_pkg::CMD_NONE;
      predicted_rsp.tx_byte = 8'd0;
      predicted_rsp.done_res = 1'b1;
      predicted_rsp.success = ok;
      seq_phase = i2crs_pkg::PH_IDLE;
      ticks_left = 16'd0;
   endfunction

   function automatic void predict_bus_response(input i2crs_pkg::req_type item);
      logic [7:0] status;
      predicted_rsp = '0;
      status = item.bus_status & i2crs_pkg::ST_MASK;
      case (item.operation)
         i2crs_pkg::OP_BEGIN: begin
            if (seq_phase == i2crs_pkg::PH_IDLE) begin
               byte_count = 8'd0;
               seq_phase = i2crs_pkg::PH_START1;
               issue_command(i2crs_pkg::CMD_START, 8'd0);
            end
         end
         i2crs_pkg::OP_TICK: begin
            if (seq_phase != i2crs_pkg::PH_IDLE) begin
               if (ticks_left <= 16'd1) end_read(1'b0);
               else ticks_left = ticks_left - 16'd1;
            end
         end
         i2crs_pkg::OP_EVENT: begin
            case (seq_phase)
               i2crs_pkg::PH_START1: begin
                  if (status == i2crs_pkg::ST_START || status == i2crs_pkg::ST_RSTART) begin
                     seq_phase = i2crs_pkg::PH_SLAW;
                     issue_command(i2crs_pkg::CMD_TX, {cfg.slave_address, 1'b0});
                  end else end_read(1'b0);
               end
               i2crs_pkg::PH_SLAW: begin
                  if (status == i2crs_pkg::ST_MT_SLA) begin
                     seq_phase = i2crs_pkg::PH_REGW;
                     issue_command(i2crs_pkg::CMD_TX, cfg.start_register);
                  end else end_read(1'b0);
               end
               i2crs_pkg::PH_REGW: begin
                  if (status == i2crs_pkg::ST_MT_DATA) begin
                     seq_phase = i2crs_pkg::PH_START2;
                     issue_command(i2crs_pkg::CMD_START, 8'd0);
                  end else end_read(1'b0);
               end
               i2crs_pkg::PH_START2: begin
                  if (status == i2crs_pkg::ST_START || status == i2crs_pkg::ST_RSTART) begin
                     seq_phase = i2crs_pkg::PH_SLAR;
                     issue_command(i2crs_pkg::CMD_TX, {cfg.slave_address, 1'b1});
                  end else end_read(1'b0);
               end
               i2crs_pkg::PH_SLAR: begin
                  if (status != i2crs_pkg::ST_MR_SLA) end_read(1'b0);
                  else if (byte_count >= cfg.read_length) end_read(1'b1);
                  else begin
                     seq_phase = i2crs_pkg::PH_READ;
                     issue_command(ack_wanted() ? i2crs_pkg::CMD_RXACK : i2crs_pkg::CMD_RXNAK,
                                   8'd0);
                  end
               end
               i2crs_pkg::PH_READ: begin
                  if (status == (ack_wanted() ? i2crs_pkg::ST_MR_ACK
                                              : i2crs_pkg::ST_MR_NACK)) begin
                     predicted_rsp.rx_valid = 1'b1;
                     predicted_rsp.rx_byte = item.bus_data;
                     predicted_rsp.rx_index = byte_count;
                     byte_count = byte_count + 8'd1;
                     if (byte_count >= cfg.read_length || byte_count == 8'd0) end_read(1'b1);
                     else issue_command(ack_wanted() ? i2crs_pkg::CMD_RXACK
                                                     : i2crs_pkg::CMD_RXNAK, 8'd0);
                  end else end_read(1'b0);
               end
               default: ;
            endcase
         end
         default: ;
      endcase
   endfunction

   function automatic string show_rsp(input i2crs_pkg::rsp_type r);
      return $sformatf("cmd=%0d tx=%02h rx_valid=%0b rx=%02h idx=%0d done=%0b ok=%0b",
                       r.bus_command, r.tx_byte, r.rx_valid, r.rx_byte, r.rx_index,
                       r.done_res, r.success);
   endfunction

   always @(posedge clock) begin
      i2crs_pkg::rsp_type got;
      i2crs_pkg::rsp_type want;
      i2crs_pkg::req_type seen;
      if (reset) begin
         cfg.slave_address = i2crs_pkg::RST_SLAVE_ADDRESS;
         cfg.start_register = i2crs_pkg::RST_START_REGISTER;
         cfg.read_length = i2crs_pkg::RST_READ_LENGTH;
         cfg.wait_limit = i2crs_pkg::RST_WAIT_LIMIT;
         seq_phase = i2crs_pkg::PH_IDLE;
         byte_count = 8'd0;
         ticks_left = 16'd0;
         expected_responses.delete();
         errors <= 0;
         pending <= 0;
         reads_ok <= 0;
         reads_aborted <= 0;
         bytes_delivered <= 0;
      end else begin
         if (csr_we) begin
            case (csr_index)
               i2crs_pkg::CSR_SLAVE_ADDRESS:  cfg.slave_address = csr_wdata[6:0];
               i2crs_pkg::CSR_START_REGISTER: cfg.start_register = csr_wdata[7:0];
               i2crs_pkg::CSR_READ_LENGTH:    cfg.read_length = csr_wdata[7:0];
               i2crs_pkg::CSR_WAIT_LIMIT:     cfg.wait_limit = csr_wdata;
               default: ;
            endcase
         end
         if (rsp_valid && rsp_ready) begin
            got.bus_command = rsp_bus_command;
            got.tx_byte = rsp_tx_byte;
            got.rx_valid = rsp_rx_valid;
            got.rx_byte = rsp_rx_byte;
            got.rx_index = rsp_rx_index;
            got.done_res = rsp_done_res;
            got.success = rsp_success;
            if (expected_responses.size() == 0) begin
               if (errors < 10)
                  $display("%0t: result with nothing expected: %s", $realtime, show_rsp(got));
               errors <= errors + 1;
            end else begin
               want = expected_responses.pop_front();
               if (got !== want) begin
                  if (errors < 10) begin
                     $display("%0t: result mismatch", $realtime);
                     $display("   expected %s", show_rsp(want));
                     $display("   actual   %s", show_rsp(got));
                  end
                  errors <= errors + 1;
               end
            end
         end
         if (req_valid && req_ready) begin
            seen.operation = req_operation;
            seen.bus_status = req_bus_status;
            seen.bus_data = req_bus_data;
            predict_bus_response(seen);
            expected_responses.push_back(predicted_rsp);
            if (predicted_rsp.rx_valid) bytes_delivered <= bytes_delivered + 1;
            if (predicted_rsp.done_res && predicted_rsp.success) reads_ok <= reads_ok + 1;
            else if (predicted_rsp.done_res) reads_aborted <= reads_aborted + 1;
         end
         pending <= expected_responses.size();
      end
   end

endmodule

>>> tb/tb_top.sv
// Testbench top for the I2C register read sequencer: stimulus, idling and verdict.
module tb_top;
   timeunit 1ns;
   timeprecision 1ps;

   localparam logic [1:0] OP_UNUSED = 2'd3;
   // Cycles without any transaction before the run is declared hung.
   localparam int STALL_LIMIT = 2000;
   localparam int READ_ITEMS = 1350;

   typedef enum {READ_CLEAN, READ_BAD_STATUS, READ_TIMEOUT} read_kind_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_ready;
   logic [1:0]  req_operation = i2crs_pkg::OP_BEGIN;
   logic [7:0]  req_bus_status = 8'd0;
   logic [7:0]  req_bus_data = 8'd0;
   logic        rsp_valid;
   logic        rsp_ready = 1'b0;
   logic [2:0]  rsp_bus_command;
   logic [7:0]  rsp_tx_byte;
   logic        rsp_rx_valid;
   logic [7:0]  rsp_rx_byte;
   logic [7:0]  rsp_rx_index;
   logic        rsp_done_res;
   logic        rsp_success;
   logic        csr_we = 1'b0;
   logic [1:0]  csr_index = i2crs_pkg::CSR_SLAVE_ADDRESS;
   logic [15:0] csr_wdata = 16'd0;

   int errors;
   int pending;
   int reads_ok;
   int reads_aborted;
   int bytes_delivered;

   int items_done = 0;
   int sent_total = 0;
   int settings_used = 0;
   int cur_len = int'(i2crs_pkg::RST_READ_LENGTH);
   int cur_wl = int'(i2crs_pkg::RST_WAIT_LIMIT);
   bit calm = 1'b0;
   int stall_left = 0;
   int idle_cycles = 0;

   i2c_register_read_sequencer dut (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_ready       (req_ready),
      .req_operation   (req_operation),
      .req_bus_status  (req_bus_status),
      .req_bus_data    (req_bus_data),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_bus_command (rsp_bus_command),
      .rsp_tx_byte     (rsp_tx_byte),
      .rsp_rx_valid    (rsp_rx_valid),
      .rsp_rx_byte     (rsp_rx_byte),
      .rsp_rx_index    (rsp_rx_index),
      .rsp_done_res    (rsp_done_res),
      .rsp_success     (rsp_success),
      .csr_we          (csr_we),
      .csr_index       (csr_index),
      .csr_wdata       (csr_wdata)
   );

   i2crs_read_checker u_checker (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_ready       (req_ready),
      .req_operation   (req_operation),
      .req_bus_status  (req_bus_status),
      .req_bus_data    (req_bus_data),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_bus_command (rsp_bus_command),
      .rsp_tx_byte     (rsp_tx_byte),
      .rsp_rx_valid    (rsp_rx_valid),
      .rsp_rx_byte     (rsp_rx_byte),
      .rsp_rx_index    (rsp_rx_index),
      .rsp_done_res    (rsp_done_res),
      .rsp_success     (rsp_success),
      .csr_we          (csr_we),
      .csr_index       (csr_index),
      .csr_wdata       (csr_wdata),
      .errors          (errors),
      .pending         (pending),
      .reads_ok        (reads_ok),
      .reads_aborted   (reads_aborted),
      .bytes_delivered (bytes_delivered)
   );

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   function automatic int pick_gap();
      int r;
      r = $urandom_range(0, 99);
      if (r < 60) return 0;
      if (r < 92) return $urandom_range(1, 3);
      return $urandom_range(8, 40);
   endfunction

   function automatic logic [7:0] rand_byte();
      return 8'($urandom_range(0, 255));
   endfunction

   always @(posedge clock) begin
      if (calm) begin
         rsp_ready <= 1'b1;
         stall_left <= 0;
      end else if (stall_left > 0) begin
         rsp_ready <= 1'b0;
         stall_left <= stall_left - 1;
      end else if ($urandom_range(0, 9) < 7) begin
         rsp_ready <= 1'b1;
      end else begin
         rsp_ready <= 1'b0;
         stall_left <= pick_gap();
      end
   end

   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready) || csr_we) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= STALL_LIMIT) begin
         $display("timeout: no transaction for %0d cycles", STALL_LIMIT);
         $display("simulation failed");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   // Valid is lowered only when a gap follows, so it never drops and rises in one step.
   task automatic send_req(input logic [1:0] op, input logic [7:0] status,
                           input logic [7:0] data, input bit useful);
      int gap;
      gap = calm ? 0 : pick_gap();
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_operation <= op;
      req_bus_status <= status;
      req_bus_data <= data;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      sent_total++;
      if (useful) items_done++;
   endtask

   task automatic wait_idle();
      req_valid <= 1'b0;
      repeat (2) @(posedge clock);
      while (pending != 0) @(posedge clock);
      repeat (6) @(posedge clock);
   endtask

   task automatic set_config(input logic [6:0] sa, input logic [7:0] sr,
                             input logic [7:0] len, input logic [15:0] wl);
      logic [15:0] junk;
      wait_idle();
      junk = 16'($urandom);
      csr_we <= 1'b1;
      csr_index <= i2crs_pkg::CSR_SLAVE_ADDRESS;
      csr_wdata <= {junk[15:7], sa};
      @(posedge clock);
      csr_index <= i2crs_pkg::CSR_START_REGISTER;
      csr_wdata <= {junk[7:0], sr};
      @(posedge clock);
      csr_index <= i2crs_pkg::CSR_READ_LENGTH;
      csr_wdata <= {junk[15:8], len};
      @(posedge clock);
      csr_index <= i2crs_pkg::CSR_WAIT_LIMIT;
      csr_wdata <= wl;
      @(posedge clock);
      csr_we <= 1'b0;
      cur_len = int'(len);
      cur_wl = int'(wl);
      settings_used++;
   endtask

   // Step 0 and 3 are the two START phases, 1 and 2 the write phase, 4 the read
   // address, and each later step one data byte.
   function automatic bit status_fits(input int step, input logic [7:0] code);
      case (step)
         0, 3: return code == i2crs_pkg::ST_START || code == i2crs_pkg::ST_RSTART;
         1: return code == i2crs_pkg::ST_MT_SLA;
         2: return code == i2crs_pkg::ST_MT_DATA;
         4: return code == i2crs_pkg::ST_MR_SLA;
         default: return code == ((step - 4 < cur_len) ? i2crs_pkg::ST_MR_ACK
                                                       : i2crs_pkg::ST_MR_NACK);
      endcase
   endfunction

   function automatic logic [7:0] good_status(input int step);
      logic [7:0] code;
      logic [7:0] low;
      case (step)
         0, 3: code = $urandom_range(0, 1) ? i2crs_pkg::ST_START : i2crs_pkg::ST_RSTART;
         1: code = i2crs_pkg::ST_MT_SLA;
         2: code = i2crs_pkg::ST_MT_DATA;
         4: code = i2crs_pkg::ST_MR_SLA;
         default: code = (step - 4 < cur_len) ? i2crs_pkg::ST_MR_ACK : i2crs_pkg::ST_MR_NACK;
      endcase
      low = 8'($urandom_range(0, 7));
      return code | low;
   endfunction

   function automatic logic [7:0] bad_status(input int step);
      logic [7:0] s;
      s = rand_byte();
      while (status_fits(step, s & i2crs_pkg::ST_MASK)) s = rand_byte();
      return s;
   endfunction

   task automatic run_read(input read_kind_type kind);
      int total;
      int fail_at;
      int step;
      total = 5 + cur_len;
      fail_at = (kind == READ_CLEAN) ? total : $urandom_range(0, total - 1);
      send_req(i2crs_pkg::OP_BEGIN, rand_byte(), rand_byte(), 1'b1);
      for (step = 0; step < total; step++) begin
         if (step == fail_at && kind == READ_TIMEOUT) begin
            repeat ((cur_wl <= 1) ? 1 : cur_wl)
               send_req(i2crs_pkg::OP_TICK, rand_byte(), rand_byte(), 1'b1);
            break;
         end
         // Ticks that stay below the wait limit must not end the read.
         if (cur_wl > 1 && $urandom_range(0, 3) == 0)
            repeat ($urandom_range(1, (cur_wl > 4) ? 3 : cur_wl - 1))
               send_req(i2crs_pkg::OP_TICK, rand_byte(), rand_byte(), 1'b1);
         if ($urandom_range(0, 39) == 0)
            send_req(i2crs_pkg::OP_BEGIN, rand_byte(), rand_byte(), 1'b0);
         if ($urandom_range(0, 39) == 0)
            send_req(OP_UNUSED, rand_byte(), rand_byte(), 1'b0);
         if (step == fail_at) begin
            send_req(i2crs_pkg::OP_EVENT, bad_status(step), rand_byte(), 1'b1);
            break;
         end
         send_req(i2crs_pkg::OP_EVENT, good_status(step), rand_byte(), 1'b1);
      end
   endtask

   // Events, ticks and unused codes while idle; no begin, so the block stays idle.
   task automatic idle_noise(input int count);
      logic [1:0] op;
      repeat (count) begin
         case ($urandom_range(0, 2))
            0: op = i2crs_pkg::OP_EVENT;
            1: op = i2crs_pkg::OP_TICK;
            default: op = OP_UNUSED;
         endcase
         send_req(op, rand_byte(), rand_byte(), 1'b0);
      end
   endtask

   initial begin
      logic [6:0]  sa;
      logic [7:0]  sr;
      logic [7:0]  len;
      logic [15:0] wl;
      int r;
      int phase_no;
      int nreads;
      repeat (5) @(posedge clock);
      reset <= 1'b0;

      // Directed part, starting from the reset register values.
      send_req(i2crs_pkg::OP_EVENT, 8'hFF, 8'hFF, 1'b1);
      send_req(i2crs_pkg::OP_TICK, 8'h00, 8'h00, 1'b1);
      send_req(OP_UNUSED, 8'h00, 8'h00, 1'b1);
      send_req(i2crs_pkg::OP_BEGIN, 8'h00, 8'h00, 1'b1);
      send_req(i2crs_pkg::OP_EVENT, i2crs_pkg::ST_START | 8'h07, 8'h00, 1'b1);
      send_req(i2crs_pkg::OP_BEGIN, 8'hFF, 8'hFF, 1'b1);
      send_req(i2crs_pkg::OP_EVENT, i2crs_pkg::ST_MT_SLA, 8'h00, 1'b1);
      send_req(i2crs_pkg::OP_EVENT, i2crs_pkg::ST_MT_DATA | 8'h05, 8'h00, 1'b1);
      send_req(i2crs_pkg::OP_EVENT, i2crs_pkg::ST_RSTART, 8'h00, 1'b1);
      send_req(i2crs_pkg::OP_EVENT, i2crs_pkg::ST_MR_SLA | 8'h07, 8'h00, 1'b1);
      send_req(i2crs_pkg::OP_EVENT, i2crs_pkg::ST_MR_ACK, 8'h00, 1'b1);
      send_req(i2crs_pkg::OP_EVENT, i2crs_pkg::ST_MR_ACK | 8'h07, 8'hFF, 1'b1);
      send_req(i2crs_pkg::OP_EVENT, i2crs_pkg::ST_MR_ACK, 8'hA5, 1'b1);
      send_req(i2crs_pkg::OP_EVENT, i2crs_pkg::ST_MR_NACK | 8'h03, 8'h5A, 1'b1);

      // Zero-length read ends with STOP right after the read address; then a
      // timeout on the first tick with a one-tick limit.
      set_config(7'h7F, 8'hFF, 8'd0, 16'd1);
      send_req(i2crs_pkg::OP_BEGIN, 8'h00, 8'h00, 1'b1);
      send_req(i2crs_pkg::OP_EVENT, i2crs_pkg::ST_START, 8'h00, 1'b1);
      send_req(i2crs_pkg::OP_EVENT, i2crs_pkg::ST_MT_SLA, 8'h00, 1'b1);
      send_req(i2crs_pkg::OP_EVENT, i2crs_pkg::ST_MT_DATA, 8'h00, 1'b1);
      send_req(i2crs_pkg::OP_EVENT, i2crs_pkg::ST_START, 8'h00, 1'b1);
      send_req(i2crs_pkg::OP_EVENT, i2crs_pkg::ST_MR_SLA, 8'h00, 1'b1);
      send_req(i2crs_pkg::OP_BEGIN, 8'h00, 8'h00, 1'b1);
      send_req(i2crs_pkg::OP_TICK, 8'h00, 8'h00, 1'b1);

      // A zero wait limit acts as a single tick.
      set_config(7'h00, 8'h00, 8'd1, 16'd0);
      send_req(i2crs_pkg::OP_BEGIN, 8'h00, 8'h00, 1'b1);
      send_req(i2crs_pkg::OP_TICK, 8'h00, 8'h00, 1'b1);

      // Random part: one register setting per phase, 3 to 6 reads (1 at length 255).
      phase_no = 0;
      while (items_done < READ_ITEMS) begin
         r = $urandom_range(0, 3);
         sa = (r == 0) ? 7'h00 : (r == 1) ? 7'h7F : 7'($urandom_range(0, 127));
         r = $urandom_range(0, 3);
         sr = (r == 0) ? 8'h00 : (r == 1) ? 8'hFF : rand_byte();
         r = $urandom_range(0, 9);
         if (phase_no == 4) len = 8'd255;
         else if (r == 0) len = 8'd0;
         else if (r == 1) len = 8'd1;
         else len = 8'($urandom_range(2, 8));
         r = $urandom_range(0, 9);
         if (r < 5) wl = 16'hFFFF;
         else if (r < 8) wl = 16'($urandom_range(2, 12));
         else if (r == 8) wl = 16'd1;
         else wl = 16'd0;
         set_config(sa, sr, len, wl);
         calm = ($urandom_range(0, 3) == 0);
         nreads = (cur_len == 255) ? 1 : $urandom_range(3, 6);
         repeat (nreads) begin
            if ($urandom_range(0, 99) < 8) idle_noise($urandom_range(1, 3));
            r = $urandom_range(0, 99);
            if (r < 72 || cur_len == 255) run_read(READ_CLEAN);
            else if (r < 87 || cur_wl > 20) run_read(READ_BAD_STATUS);
            else run_read(READ_TIMEOUT);
         end
         phase_no++;
      end

      calm = 1'b0;
      wait_idle();
      $display("covered %0d input transactions over %0d register settings", sent_total,
               settings_used + 1);
      $display("%0d reads completed, %0d aborted, %0d data bytes delivered", reads_ok,
               reads_aborted, bytes_delivered);
      if (errors == 0 && pending == 0) begin
         $display("simulation ok");
      end else begin
         $display("simulation failed");
      end
      $finish;
   end

endmodule

>>> files.f
hw/rtl/i2crs_pkg.sv
hw/rtl/i2crs_csr.sv
hw/rtl/i2crs_seq.sv
hw/rtl/i2c_register_read_sequencer.sv
hw/rtl/i2crs_checker.sv
tb/i2crs_read_checker.sv
tb/tb_top.sv
